[src/hnm_pkg.sv]
// Package with shared types and constants of the height map to normal map block.
`default_nettype none

package hnm_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int NORM_W     = 10;
    localparam int COORD_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int GRAD_W     = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [CFG_DATA_W-1:0] MAX_HEIGHT = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic                     done;
    } t_job;

endpackage

`default_nettype wire

[src/hnm_ifs.sv]
// Stream and configuration interfaces of the height map to normal map block.
`default_nettype none

interface hnm_in_if;
    logic                          valid;
    logic                          ready;
    logic [hnm_pkg::SAMPLE_W-1:0]  height_sample;
    modport source (output valid, output height_sample, input ready);
    modport sink (input valid, input height_sample, output ready);
endinterface

interface hnm_out_if;
    logic                          valid;
    logic                          ready;
    logic [hnm_pkg::NORM_W-1:0]    normal_x;
    logic [hnm_pkg::NORM_W-1:0]    normal_y;
    logic [hnm_pkg::NORM_W-1:0]    normal_z;
    logic [hnm_pkg::COORD_W-1:0]   pixel_col;
    logic [hnm_pkg::COORD_W-1:0]   pixel_row;
    logic                          frame_done;
    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output pixel_col, output pixel_row, output frame_done, input ready);
    modport sink (input valid, input normal_x, input normal_y, input normal_z,
                  input pixel_col, input pixel_row, input frame_done, output ready);
endinterface

interface hnm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hnm_pkg::CFG_IDX_W-1:0]   index;
    logic [hnm_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/hnm_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module hnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/hnm_front.sv]
// Front part: configuration, pixel counters, line buffers and gradient jobs.
`default_nettype none

module hnm_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    hnm_in_if.sink         i_sample_ch,
    hnm_cfg_if.sink        i_cfg_ch,
    input  wire logic      i_full,
    output logic           o_push,
    output hnm_pkg::t_job  o_job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int AW = CW + 1;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_RA   = 3'd1;
    localparam logic [2:0] F_RB   = 3'd2;
    localparam logic [2:0] F_RC   = 3'd3;
    localparam logic [2:0] F_WR   = 3'd4;
    localparam logic [2:0] F_J0   = 3'd5;
    localparam logic [2:0] F_J1   = 3'd6;
    localparam logic [2:0] F_J2   = 3'd7;

    logic [2:0]                        r_state, n_state;
    logic [hnm_pkg::CFG_DATA_W-1:0]    r_width, r_height;
    logic [CW-1:0]                     r_col, r_x;
    logic [hnm_pkg::COORD_W-1:0]       r_row, r_y;
    logic [hnm_pkg::SAMPLE_W-1:0]      r_smp, r_cur1, r_cur2, r_up, r_lft, r_rgt;

    logic [31:0]                       w32;
    logic [WW-1:0]                     w_eff;
    logic [CW-1:0]                     wm1;
    logic [hnm_pkg::CFG_DATA_W-1:0]    h_eff;
    logic [hnm_pkg::COORD_W-1:0]       hm1;
    logic                              accept, y_ge1, last_row, x_ge1, x_ge2, x_last;
    logic [CW-1:0]                     xm1, xp1;
    logic [AW-1:0]                     raddr, waddr;
    logic [hnm_pkg::SAMPLE_W-1:0]      rdata, d_smp, e_smp;
    logic [31:0]                       x32, xm1_32;
    logic                              cond;

    assign w32   = {{(32 - hnm_pkg::CFG_DATA_W){1'b0}}, r_width};
    assign w_eff = (r_width == '0) ? WW'(1) :
                   ((w32 > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w32[WW-1:0]);
    assign wm1   = CW'(w_eff - WW'(1));
    assign h_eff = (r_height == '0) ? 13'd1 :
                   ((r_height > hnm_pkg::MAX_HEIGHT) ? hnm_pkg::MAX_HEIGHT : r_height);
    assign hm1   = hnm_pkg::COORD_W'(h_eff - 13'd1);

    assign accept             = (r_state == F_IDLE) && i_sample_ch.valid;
    assign i_sample_ch.ready  = (r_state == F_IDLE);
    assign i_cfg_ch.ready     = 1'b1;

    assign y_ge1    = (r_y != '0);
    assign last_row = (r_y == hm1);
    assign x_ge1    = (r_x != '0);
    assign x_ge2    = (r_x > CW'(1));
    assign x_last   = (r_x == wm1);
    assign xm1      = x_ge1 ? (r_x - CW'(1)) : '0;
    assign xp1      = x_last ? r_x : (r_x + CW'(1));
    assign x32      = 32'(r_x);
    assign xm1_32   = 32'(xm1);
    assign d_smp    = x_ge2 ? r_cur2 : r_cur1;
    assign e_smp    = x_ge1 ? r_cur1 : r_smp;
    assign waddr    = {r_y[0], r_x};

    always_comb begin
        unique case (r_state)
            F_RA:    raddr = {((r_y == 12'd1) ? ~r_y[0] : r_y[0]), r_x};
            F_RB:    raddr = {~r_y[0], xm1};
            default: raddr = {~r_y[0], xp1};
        endcase
    end

    hnm_ram #(
        .WIDTH (hnm_pkg::SAMPLE_W),
        .DEPTH (2 ** AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == F_WR),
        .i_waddr (waddr),
        .i_wdata (r_smp),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_job = '0;
        cond  = 1'b0;
        unique case (r_state)
            F_J0: begin
                cond      = y_ge1;
                o_job.gx  = $signed({1'b0, r_lft}) - $signed({1'b0, r_rgt});
                o_job.gy  = $signed({1'b0, r_up}) - $signed({1'b0, r_smp});
                o_job.col = x32[hnm_pkg::COORD_W-1:0];
                o_job.row = r_y - 12'd1;
            end
            F_J1: begin
                cond      = last_row && x_ge1;
                o_job.gx  = $signed({1'b0, d_smp}) - $signed({1'b0, r_smp});
                o_job.gy  = y_ge1 ? ($signed({1'b0, r_lft}) - $signed({1'b0, r_cur1})) : '0;
                o_job.col = xm1_32[hnm_pkg::COORD_W-1:0];
                o_job.row = r_y;
            end
            F_J2: begin
                cond       = last_row && x_last;
                o_job.gx   = $signed({1'b0, e_smp}) - $signed({1'b0, r_smp});
                o_job.gy   = y_ge1 ? ($signed({1'b0, r_rgt}) - $signed({1'b0, r_smp})) : '0;
                o_job.col  = x32[hnm_pkg::COORD_W-1:0];
                o_job.row  = r_y;
                o_job.done = 1'b1;
            end
            default: begin
                cond = 1'b0;
            end
        endcase
    end

    assign o_push = cond && !i_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (accept) n_state = F_RA;
            F_RA:    n_state = F_RB;
            F_RB:    n_state = F_RC;
            F_RC:    n_state = F_WR;
            F_WR:    n_state = F_J0;
            F_J0:    if (!cond || !i_full) n_state = F_J1;
            F_J1:    if (!cond || !i_full) n_state = F_J2;
            F_J2:    if (!cond || !i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_width  <= 13'd256;
            r_height <= 13'd256;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_ch.valid && (i_cfg_ch.index == hnm_pkg::CFG_IMAGE_WIDTH ||
                                   i_cfg_ch.index == hnm_pkg::CFG_IMAGE_HEIGHT)) begin
                if (i_cfg_ch.index == hnm_pkg::CFG_IMAGE_WIDTH) begin
                    r_width <= i_cfg_ch.data;
                end else begin
                    r_height <= i_cfg_ch.data;
                end
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (r_col == wm1) begin
                    r_col <= '0;
                    r_row <= (r_row == hm1) ? '0 : (r_row + 12'd1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= r_col;
            r_y   <= r_row;
            r_smp <= i_sample_ch.height_sample;
        end
        if (r_state == F_RB) begin
            r_up <= rdata;
        end
        if (r_state == F_RC) begin
            r_lft <= rdata;
        end
        if (r_state == F_WR) begin
            r_rgt <= rdata;
        end
        if (r_state == F_J2 && (!cond || !i_full)) begin
            r_cur2 <= r_cur1;
            r_cur1 <= r_smp;
        end
    end

endmodule

`default_nettype wire

[src/hnm_queue.sv]
// Short job queue between the front and the back part.
`default_nettype none

module hnm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hnm_pkg::t_job  i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output hnm_pkg::t_job       o_job,
    output logic                o_empty
);

    localparam int PW = $clog2(hnm_pkg::QUEUE_DEPTH);

    hnm_pkg::t_job   r_mem [hnm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW + 1)'(hnm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

[src/hnm_back.sv]
// Back part: reciprocal square root iteration, quantization and output register.
`default_nettype none

module hnm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire hnm_pkg::t_job  i_job,
    output logic                o_pop,
    hnm_out_if.source           o_normal_ch
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_SQ   = 3'd1;
    localparam logic [2:0] B_RS   = 3'd2;
    localparam logic [2:0] B_QT   = 3'd3;
    localparam logic [2:0] B_LD   = 3'd4;

    localparam logic [57:0] RS_LIMIT = 58'd1 << 48;

    logic [2:0]                   r_state, n_state;
    hnm_pkg::t_job                r_job;
    logic [21:0]                  r_s;
    logic [16:0]                  r_r;
    logic [48:0]                  r_p;
    logic [39:0]                  r_a;
    logic [4:0]                   r_b;
    logic [1:0]                   r_qs;
    logic signed [28:0]           r_prod;
    logic [hnm_pkg::NORM_W-1:0]   r_n [3];
    logic                         r_ov;

    logic signed [17:0]           sqx, sqy;
    logic [17:0]                  sum;
    logic [21:0]                  s_c;
    logic [57:0]                  cand;
    logic                         fits;
    logic signed [10:0]           v_sel;
    logic signed [28:0]           prod_c;
    logic                         out_free;

    function automatic logic [hnm_pkg::NORM_W-1:0] quant(input logic signed [28:0] p);
        logic signed [29:0] t;
        logic [25:0]        tu;
        logic [36:0]        m;
        logic [11:0]        q;
        t  = 30'sd16777216 + 30'(p);
        tu = (t < 0) ? '0 : t[25:0];
        m  = ({1'b0, tu, 10'd0} - {11'd0, tu}) + 37'd16777216;
        q  = m[36:25];
        return (q > 12'd1023) ? 10'd1023 : q[9:0];
    endfunction

    assign sqx  = r_job.gx * r_job.gx;
    assign sqy  = r_job.gy * r_job.gy;
    assign sum  = 18'(sqx) + 18'(sqy);
    assign s_c  = {sum, 4'd0} + 22'd65025;

    assign cand = {9'd0, r_p} + ({18'd0, r_a} << (6'(r_b) + 6'd1)) +
                  ({36'd0, r_s} << {r_b, 1'b0});
    assign fits = (cand <= RS_LIMIT);

    always_comb begin
        case (r_qs)
            2'd0:    v_sel = {r_job.gx, 2'b00};
            2'd1:    v_sel = {r_job.gy, 2'b00};
            default: v_sel = 11'sd255;
        endcase
    end

    assign prod_c   = v_sel * $signed({1'b0, r_r});
    assign out_free = !r_ov || o_normal_ch.ready;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_empty) n_state = B_SQ;
            B_SQ:    n_state = B_RS;
            B_RS:    if (r_b == '0) n_state = B_QT;
            B_QT:    if (r_qs == 2'd3) n_state = B_LD;
            B_LD:    if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_LD && out_free) begin
                r_ov <= 1'b1;
            end else if (o_normal_ch.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_SQ) begin
            r_s <= s_c;
            r_r <= '0;
            r_p <= '0;
            r_a <= '0;
            r_b <= 5'd16;
        end
        if (r_state == B_RS) begin
            if (fits) begin
                r_r <= r_r | (17'd1 << r_b);
                r_p <= cand[48:0];
                r_a <= r_a + ({18'd0, r_s} << r_b);
            end
            r_b  <= r_b - 5'd1;
            r_qs <= '0;
        end
        if (r_state == B_QT) begin
            r_prod <= prod_c;
            if (r_qs != 2'd0) begin
                r_n[r_qs - 2'd1] <= quant(r_prod);
            end
            r_qs <= r_qs + 2'd1;
        end
        if (r_state == B_LD && out_free) begin
            o_normal_ch.normal_x   <= r_n[0];
            o_normal_ch.normal_y   <= r_n[1];
            o_normal_ch.normal_z   <= r_n[2];
            o_normal_ch.pixel_col  <= r_job.col;
            o_normal_ch.pixel_row  <= r_job.row;
            o_normal_ch.frame_done <= r_job.done;
        end
    end

    assign o_normal_ch.valid = r_ov;

endmodule

`default_nettype wire

[src/heightmap_to_normal_map_top.sv]
// Top level: the front part, the job queue and the back part, with checks.
// The front takes a new sample only once it is done with the jobs of the last one,
// and waits while the four-entry job queue is full. The back works on one normal
// at a time; its pace is set by the 17-step reciprocal square root.
// A sample on the last row can cause up to three normals, so that row runs slower.
// Reset is synchronous: it clears the counters, the queue and the output valid.
`default_nettype none

module heightmap_to_normal_map_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hnm_in_if.sink     i_sample_ch,
    hnm_cfg_if.sink    i_cfg_ch,
    hnm_out_if.source  o_normal_ch
);

    hnm_pkg::t_job  push_job, pop_job;
    logic           push, full, pop, empty;

    hnm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (i_sample_ch),
        .i_cfg_ch    (i_cfg_ch),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    hnm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    hnm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_normal_ch (o_normal_ch)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && empty))
        else $error("job popped from an empty queue");

    a_z_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_normal_ch.valid |-> o_normal_ch.normal_z[9])
        else $error("normal z below half scale");

endmodule

`default_nettype wire
